/* rtl/integer_to_ascii_formatter_core_defines.svh */
// ----------------------------------------------------------------------------
// integer to ascii formatter assertion macros
// shared concurrent check templates for the formatter rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define ITOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// types, constants and helpers shared by the formatter rtl
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_UDEC = 2'd0;
  localparam func_t FUNC_SDEC = 2'd1;
  localparam func_t FUNC_HEX  = 2'd2;

  localparam int NUM_CELLS  = 10;  // decimal digits of a 32-bit magnitude
  localparam int HEX_CELLS  = 8;   // nibbles of a 32-bit value
  localparam int CONV_STEPS = 16;  // two binary bits per cycle

  localparam logic [3:0] CONV_LAST = 4'(CONV_STEPS - 1);
  localparam logic [3:0] HEX_MAX   = 4'(HEX_CELLS);
  localparam logic [7:0] CH_MINUS  = 8'h2d;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PICK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // add-3 correction of one bcd digit ahead of a shift
  function automatic logic [3:0] bcd_adj(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

  function automatic logic [7:0] char_of(input logic [3:0] d);
    return HEX_CHARS[d];
  endfunction

endpackage

`default_nettype wire

/* rtl/itoa_if.sv */
// ----------------------------------------------------------------------------
// itoa channel interfaces
// valid/ready channels for value beats in and character beats out
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_in_if;
  import itoa_pkg::*;

  logic        valid;
  logic        ready;
  func_t       func;
  logic [31:0] value;
  logic [7:0]  width;

  modport source (output valid, func, value, width, input ready);
  modport sink   (input valid, func, value, width, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

`default_nettype wire

/* rtl/itoa_cell.sv */
// ----------------------------------------------------------------------------
// itoa_cell
// one digit cell of the double-dabble chain, two bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire itoa_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [3:0]            load_digit_i,
  input  wire logic                  in_hi_i,
  input  wire logic                  in_lo_i,
  output logic                       out_hi_o,
  output logic                       out_lo_o,
  output logic [3:0]                 digit_o
);
  import itoa_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] s1, t1, s2;

  // two adjust-and-shift steps; carries come from the lower neighbor
  always_comb begin
    s1       = bcd_adj(digit_q);
    out_hi_o = s1[3];
    t1       = {s1[2:0], in_hi_i};
    s2       = bcd_adj(t1);
    out_lo_o = s2[3];
    digit_d  = digit_q;
    if (ctrl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctrl_i.shift) begin
      digit_d = {s2[2:0], in_lo_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

/* rtl/integer_to_ascii_formatter_core.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// prints a 32-bit value as ascii, unsigned/signed decimal or lower-case hex
// ----------------------------------------------------------------------------
//
//  port    dir  modport  beat contents
//  in_i    in   sink     func, value, width (one value to print)
//  out_o   out  source   ch, last (one character, last marks the final one)
//
//  decimal: accept, conversion, pick, then up to 11 characters (sign and ten digits);
//  the conversion length is set by the bcd cell chain taking two bits a cycle
//  hex: accept, pick, then up to 8 characters, nibbles load directly
//  one value is in flight at a time; the next is taken once its final
//  character sits in the output register
//  a stalled sink freezes the emit counter; reset clears control state and the cell digits
//
`default_nettype none

module integer_to_ascii_formatter_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;
  `include "integer_to_ascii_formatter_core_defines.svh"

  // control
  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;         // conversion step
  logic [3:0] idx_q, idx_d;         // digit being printed
  logic       minus_q, minus_d;     // sign character pending
  func_t      func_q, func_d;
  logic [3:0] wsel_q, wsel_d;       // saturated hex width

  // payload
  logic [31:0] bin_q, bin_d;        // magnitude, shifted out msb first

  // output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] och_q, och_d;
  logic       olast_q, olast_d;

  // cell chain
  cell_ctrl_t cell_ctrl;
  logic [3:0] load_digit [NUM_CELLS];
  logic [3:0] digits     [NUM_CELLS];
  logic       hi_chain   [NUM_CELLS+1];
  logic       lo_chain   [NUM_CELLS+1];

  logic       accept;
  logic       in_hex;
  logic       in_neg;
  logic       out_free;
  logic       emit_fire;
  logic       last_d;
  logic [7:0] char_d;
  logic [3:0] msd;

  assign accept   = in_i.valid && in_i.ready;
  assign in_hex   = (in_i.func != FUNC_UDEC) && (in_i.func != FUNC_SDEC);
  assign in_neg   = (in_i.func == FUNC_SDEC) && in_i.value[31];
  assign out_free = !ovalid_q || out_o.ready;

  // binary bits enter the chain at the least significant cell
  assign hi_chain[0] = bin_q[31];
  assign lo_chain[0] = bin_q[30];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i < HEX_CELLS) begin : g_nib
      assign load_digit[i] = in_hex ? in_i.value[4*i +: 4] : 4'd0;
    end else begin : g_top
      assign load_digit[i] = 4'd0;
    end

    itoa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .load_digit_i (load_digit[i]),
      .in_hi_i      (hi_chain[i]),
      .in_lo_i      (lo_chain[i]),
      .out_hi_o     (hi_chain[i+1]),
      .out_lo_o     (lo_chain[i+1]),
      .digit_o      (digits[i])
    );
  end

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    msd = 4'd0;
    for (int i = 1; i < NUM_CELLS; i++) begin
      if (digits[i] != 4'd0) begin
        msd = 4'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_hex ? ST_PICK : ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_q == CONV_LAST) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && last_d) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready      = (state_q == ST_IDLE);
    cell_ctrl.load  = accept;
    cell_ctrl.shift = (state_q == ST_CONV);
    emit_fire       = (state_q == ST_EMIT) && out_free;
    last_d          = !minus_q && (idx_q == 4'd0);
    char_d          = minus_q ? CH_MINUS : char_of(digits[idx_q]);
  end

  // datapath next values
  always_comb begin
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    minus_d = minus_q;
    func_d  = func_q;
    wsel_d  = wsel_q;
    bin_d   = bin_q;
    if (accept) begin
      cnt_d   = 4'd0;
      minus_d = in_neg;
      func_d  = in_i.func;
      wsel_d  = (in_i.width > 8'(HEX_MAX)) ? HEX_MAX : in_i.width[3:0];
      bin_d   = in_neg ? (~in_i.value + 32'd1) : in_i.value;
    end else if (state_q == ST_CONV) begin
      cnt_d = cnt_q + 4'd1;
      bin_d = {bin_q[29:0], 2'b00};
    end else if (state_q == ST_PICK) begin
      // fixed hex width picks its own start digit, else skip leading zeros
      if ((func_q != FUNC_UDEC) && (func_q != FUNC_SDEC) && (wsel_q != 4'd0)) begin
        idx_d = wsel_q - 4'd1;
      end else begin
        idx_d = msd;
      end
    end else if (emit_fire) begin
      if (minus_q) begin
        minus_d = 1'b0;
      end else if (idx_q != 4'd0) begin
        idx_d = idx_q - 4'd1;
      end
    end
  end

  // output register: holds a beat while the sink stalls
  always_comb begin
    ovalid_d = ovalid_q;
    och_d    = och_q;
    olast_d  = olast_q;
    if (emit_fire) begin
      ovalid_d = 1'b1;
      och_d    = char_d;
      olast_d  = last_d;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= 4'd0;
      idx_q    <= 4'd0;
      minus_q  <= 1'b0;
      func_q   <= FUNC_UDEC;
      wsel_q   <= 4'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      minus_q  <= minus_d;
      func_q   <= func_d;
      wsel_q   <= wsel_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.ch    = och_q;
  assign out_o.last  = olast_q;

  // final character of a value returns the sequencer to idle
  `ITOA_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, emit_fire && last_d, state_q == ST_IDLE)
  // conversion runs exactly its step count, then picks the start digit
  `ITOA_ASSERT_NEXT(a_conv_done, clk_i, rst_ni, (state_q == ST_CONV) && (cnt_q == CONV_LAST), state_q == ST_PICK)
  // the printed digit always lies inside the chain
  `ITOA_ASSERT_IMP(a_idx_range, clk_i, rst_ni, state_q == ST_EMIT, idx_q < 4'(NUM_CELLS))
  // a sign character only belongs to signed decimal
  `ITOA_ASSERT_IMP(a_minus_sdec, clk_i, rst_ni, minus_q, func_q == FUNC_SDEC)

endmodule

`default_nettype wire
